// ----- hdl/fbre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbre_pkg
// shared types, codes and defaults of the rectangle blend engine
// ----------------------------------------------------------------------------
package fbre_pkg;

   // default sizing
   localparam int DEF_MAX_DIM  = 128;
   localparam int DEF_FB_DEPTH = 16384;

   // signed width used for clipping, holds pos + size without wrap
   localparam int CLIP_W = 18;

   // configuration
   localparam logic [7:0] CANVAS_RESET = 8'd128;
   localparam logic       CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic       CSR_CANVAS_HEIGHT = 1'b1;

   // command codes
   localparam logic FUNC_DRAW = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // blend modes
   localparam logic [1:0] MODE_REPLACE  = 2'd0;
   localparam logic [1:0] MODE_ALPHA    = 2'd1;
   localparam logic [1:0] MODE_ADDITIVE = 2'd2;
   localparam logic [1:0] MODE_AVERAGE  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load_cmd;
      logic setup;
      logic base;
      logic pix_read;
      logic pix_mul;
      logic pix_write;
      logic clear_step;
      logic load_rsp;
   } fbre_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic hit;
      logic last_pixel;
   } fbre_sts_type;

endpackage : fbre_pkg
`default_nettype wire

// ----- hdl/framebuffer_blend_rectangle_engine_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_blend_rectangle_engine_top
// rgb888 frame store with clipped rectangle draws, four blend modes and reads
// steps: setup and row base, then one store read for an in-bounds read, none for a miss,
//   and for a draw one read-modify-write per clipped pixel
// throughput: one word at a time, the next taken the cycle after its result is loaded
// reset: synchronous; store swept to black, no word taken meanwhile
// ----------------------------------------------------------------------------
module framebuffer_blend_rectangle_engine_top
   import fbre_pkg::*;
#(
   parameter int MAX_DIM  = DEF_MAX_DIM,   // largest canvas side in use
   parameter int FB_DEPTH = DEF_FB_DEPTH   // frame store entries
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // command words
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_func,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_rect_width,
   input  wire logic signed [15:0] req_rect_height,
   input  wire logic [7:0]         req_src_red,
   input  wire logic [7:0]         req_src_green,
   input  wire logic [7:0]         req_src_blue,
   input  wire logic [7:0]         req_src_alpha,
   input  wire logic [1:0]         req_blend_mode,
   // result words
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [7:0]         rsp_read_red,
   output      logic [7:0]         rsp_read_green,
   output      logic [7:0]         rsp_read_blue,
   output      logic               rsp_hit_canvas,
   // canvas size registers
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata
);

   fbre_cmd_type cmd;   // per-cycle strobes from the sequencer
   fbre_sts_type sts;   // clip result, walk position and clear progress

   // sequencer: clear sweep, then per word setup, row base, pixel loop, result
   // a result still waiting on rsp_ready holds the sequencer before loading the next
   fbre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: canvas registers, clipping, frame store and blend arithmetic
   // canvas writes are taken during the clear sweep as well
   fbre_datapath #(
      .MAX_DIM  (MAX_DIM),
      .FB_DEPTH (FB_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_src_red     (req_src_red),
      .req_src_green   (req_src_green),
      .req_src_blue    (req_src_blue),
      .req_src_alpha   (req_src_alpha),
      .req_blend_mode  (req_blend_mode),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_read_red    (rsp_read_red),
      .rsp_read_green  (rsp_read_green),
      .rsp_read_blue   (rsp_read_blue),
      .rsp_hit_canvas  (rsp_hit_canvas)
   );

endmodule : framebuffer_blend_rectangle_engine_top
`default_nettype wire

// ----- hdl/fbre_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbre_datapath
// frame store, canvas registers, clipping, pixel walk and blend arithmetic
// ----------------------------------------------------------------------------
module fbre_datapath
   import fbre_pkg::*;
#(
   parameter int MAX_DIM  = DEF_MAX_DIM,
   parameter int FB_DEPTH = DEF_FB_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fbre_cmd_type       cmd,
   output      fbre_sts_type       sts,
   input  wire logic               req_func,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_rect_width,
   input  wire logic signed [15:0] req_rect_height,
   input  wire logic [7:0]         req_src_red,
   input  wire logic [7:0]         req_src_green,
   input  wire logic [7:0]         req_src_blue,
   input  wire logic [7:0]         req_src_alpha,
   input  wire logic [1:0]         req_blend_mode,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata,
   output      logic [7:0]         rsp_read_red,
   output      logic [7:0]         rsp_read_green,
   output      logic [7:0]         rsp_read_blue,
   output      logic               rsp_hit_canvas
);

   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
   localparam int AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
   localparam int IDX_W = (2 * DIM_W > AW) ? 2 * DIM_W : AW + 1;
   localparam int EW    = (DIM_W > 8) ? DIM_W : 8;
   localparam logic signed [CLIP_W-1:0] CLIP_ZERO = '0;
   localparam logic signed [CLIP_W-1:0] CLIP_ONE  = CLIP_W'(1);

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [7:0] blend(input logic [1:0]  mode,
                                        input logic [7:0]  d,
                                        input logic [7:0]  s,
                                        input logic [15:0] pinv,
                                        input logic [15:0] psrc);
      logic [8:0] sum;
      logic [8:0] avg;
      logic [7:0] res;
      sum = {1'b0, d} + {1'b0, div255(psrc)};
      avg = {1'b0, d} + {1'b0, s};
      unique case (mode)
         MODE_REPLACE:  res = s;
         MODE_ALPHA:    res = div255(pinv + psrc);
         MODE_ADDITIVE: res = sum[8] ? 8'd255 : sum[7:0];
         MODE_AVERAGE:  res = avg[8:1];
         default:       res = s;
      endcase
      return res;
   endfunction

   // canvas registers
   logic [7:0] cw_reg_ff, ch_reg_ff;
   logic [DIM_W-1:0] cw_eff, ch_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_reg_ff <= CANVAS_RESET;
         ch_reg_ff <= CANVAS_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_CANVAS_WIDTH) cw_reg_ff <= csr_wdata;
         if (csr_index == CSR_CANVAS_HEIGHT) ch_reg_ff <= csr_wdata;
      end
   end

   assign cw_eff = (EW'(cw_reg_ff) > EW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cw_reg_ff);
   assign ch_eff = (EW'(ch_reg_ff) > EW'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(ch_reg_ff);

   // command word
   logic               func_ff;
   logic signed [15:0] px_ff, py_ff, rw_ff, rh_ff;
   logic [7:0]         src_ff [3];
   logic [7:0]         alpha_ff;
   logic [1:0]         mode_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         func_ff   <= req_func;
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         rw_ff     <= req_rect_width;
         rh_ff     <= req_rect_height;
         src_ff[2] <= req_src_red;
         src_ff[1] <= req_src_green;
         src_ff[0] <= req_src_blue;
         alpha_ff  <= req_src_alpha;
         mode_ff   <= req_blend_mode;
      end
   end

   // clipping
   logic signed [CLIP_W-1:0] px_s, py_s, rw_s, rh_s, cw_s, ch_s;
   logic signed [CLIP_W-1:0] x0c, y0c, x1c, y1c, xe_s, ye_s, xl_s, yl_s;
   logic draw_hit, read_hit;

   assign px_s = CLIP_W'(px_ff);
   assign py_s = CLIP_W'(py_ff);
   assign rw_s = CLIP_W'(rw_ff);
   assign rh_s = CLIP_W'(rh_ff);
   assign cw_s = $signed({{(CLIP_W - DIM_W){1'b0}}, cw_eff});
   assign ch_s = $signed({{(CLIP_W - DIM_W){1'b0}}, ch_eff});
   assign xe_s = px_s + rw_s;
   assign ye_s = py_s + rh_s;
   assign x0c  = (px_s < CLIP_ZERO) ? CLIP_ZERO : px_s;
   assign y0c  = (py_s < CLIP_ZERO) ? CLIP_ZERO : py_s;
   assign x1c  = (xe_s > cw_s) ? cw_s : xe_s;
   assign y1c  = (ye_s > ch_s) ? ch_s : ye_s;
   assign xl_s = x1c - CLIP_ONE;
   assign yl_s = y1c - CLIP_ONE;

   assign draw_hit = (rw_s > CLIP_ZERO) && (rh_s > CLIP_ZERO) && (x0c < x1c) && (y0c < y1c);
   assign read_hit = (px_s >= CLIP_ZERO) && (py_s >= CLIP_ZERO) && (px_s < cw_s) &&
                     (py_s < ch_s);

   // pixel walk
   logic             hit_ff;
   logic [DIM_W-1:0] x0_ff, xl_ff, yl_ff, col_ff, row_ff;
   logic [IDX_W-1:0] row_base_ff;
   logic [2*DIM_W-1:0] row_prod;
   logic [IDX_W-1:0] idx;
   logic             in_range;
   logic [AW-1:0]    addr;

   assign row_prod = (2*DIM_W)'(row_ff) * (2*DIM_W)'(cw_eff);
   assign idx      = row_base_ff + IDX_W'(col_ff);
   assign in_range = idx < IDX_W'(FB_DEPTH);
   assign addr     = idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         hit_ff <= (func_ff == FUNC_READ) ? read_hit : draw_hit;
         x0_ff  <= x0c[DIM_W-1:0];
         col_ff <= x0c[DIM_W-1:0];
         row_ff <= y0c[DIM_W-1:0];
         xl_ff  <= xl_s[DIM_W-1:0];
         yl_ff  <= yl_s[DIM_W-1:0];
      end else if (cmd.pix_write) begin
         if (col_ff == xl_ff) begin
            col_ff      <= x0_ff;
            row_ff      <= row_ff + DIM_W'(1);
            row_base_ff <= row_base_ff + IDX_W'(cw_eff);
         end else begin
            col_ff <= col_ff + DIM_W'(1);
         end
      end
      if (cmd.base) row_base_ff <= IDX_W'(row_prod);
   end

   // frame store
   logic [23:0]   mem [FB_DEPTH];
   logic [23:0]   rd_data_ff;
   logic          in_range_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [23:0]   mem_wdata;
   logic [23:0]   blend_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   assign mem_we    = cmd.clear_step || (cmd.pix_write && in_range_ff);
   assign mem_waddr = cmd.clear_step ? clr_addr_ff : addr;
   assign mem_wdata = cmd.clear_step ? 24'd0 : blend_word;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.pix_read) begin
         in_range_ff <= in_range;
         if (in_range) rd_data_ff <= mem[addr];
      end
   end

   // blend: products registered, then divide and select
   logic [7:0]  dst_ff  [3];
   logic [15:0] pinv_ff [3];
   logic [15:0] psrc_ff [3];
   logic [7:0]  inv_alpha;

   assign inv_alpha = 8'd255 - alpha_ff;

   always_ff @(posedge clock) begin
      if (cmd.pix_mul) begin
         for (int c = 0; c < 3; c++) begin
            dst_ff[c]  <= rd_data_ff[8*c +: 8];
            pinv_ff[c] <= {8'd0, rd_data_ff[8*c +: 8]} * {8'd0, inv_alpha};
            psrc_ff[c] <= {8'd0, src_ff[c]} * {8'd0, alpha_ff};
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_word[8*c +: 8] = blend(mode_ff, dst_ff[c], src_ff[c], pinv_ff[c], psrc_ff[c]);
      end
   end

   // result word
   logic show_pixel;
   assign show_pixel = (func_ff == FUNC_READ) && hit_ff && in_range_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_red   <= show_pixel ? rd_data_ff[23:16] : 8'd0;
         rsp_read_green <= show_pixel ? rd_data_ff[15:8]  : 8'd0;
         rsp_read_blue  <= show_pixel ? rd_data_ff[7:0]   : 8'd0;
         rsp_hit_canvas <= hit_ff;
      end
   end

   assign sts.clear_last = (clr_addr_ff == AW'(FB_DEPTH - 1));
   assign sts.is_read    = (func_ff == FUNC_READ);
   assign sts.hit        = hit_ff;
   assign sts.last_pixel = (col_ff == xl_ff) && (row_ff == yl_ff);

endmodule : fbre_datapath
`default_nettype wire

// ----- hdl/fbre_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbre_ctrl
// sequencer for clearing, command setup, pixel read-modify-write and result
// ----------------------------------------------------------------------------
module fbre_ctrl
   import fbre_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      fbre_cmd_type cmd,
   input  wire fbre_sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_BASE,
      S_PIX_RD,
      S_PIX_MUL,
      S_PIX_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_cmd = 1'b1;
               state_in     = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_BASE;
         end
         S_BASE: begin
            cmd.base = 1'b1;
            state_in = sts.hit ? S_PIX_RD : S_DONE;
         end
         S_PIX_RD: begin
            cmd.pix_read = 1'b1;
            state_in     = sts.is_read ? S_DONE : S_PIX_MUL;
         end
         S_PIX_MUL: begin
            cmd.pix_mul = 1'b1;
            state_in    = S_PIX_WR;
         end
         S_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = sts.last_pixel ? S_DONE : S_PIX_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule : fbre_ctrl
`default_nettype wire
